FILE: src/wcm_pkg.sv
// ----------------------------------------------------------------------------
// wcm_pkg: shared types and arithmetic for the world contact manifold
// Q16.16 vector type, saturating helpers, normalizer step function.
// ----------------------------------------------------------------------------
package wcm_pkg;

  localparam int MAX_POINTS_DEF = 2;
  localparam logic [30:0] MIN_DIST_RST = 31'd1;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  // root steps then quotient bits of the normalizer
  localparam int SQRT_STEPS     = 32;
  localparam int QUOT_BITS      = 17;
  localparam int NORM_STEPS     = SQRT_STEPS + QUOT_BITS;
  localparam int NORM_PER_STAGE = 4;
  localparam int NORM_STAGES    = (NORM_STEPS + NORM_PER_STAGE - 1) / NORM_PER_STAGE;

  // MT_UNUSED: no manifold, result word carries zeros
  typedef enum logic [1:0] {
    MT_CIRCLES = 2'd0,
    MT_FACE_A  = 2'd1,
    MT_FACE_B  = 2'd2,
    MT_UNUSED  = 2'd3
  } mtype_t;

  typedef struct packed {
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec_t;

  typedef struct packed {
    logic [63:0] v;
    logic [35:0] rem;
    logic [31:0] root;
    logic [48:0] rx;
    logic [48:0] ry;
    logic [16:0] qx;
    logic [16:0] qy;
    logic        negx;
    logic        negy;
  } nrm_t;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  function automatic logic signed [63:0] sx32(logic signed [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic logic signed [63:0] sx48(logic signed [47:0] a);
    return {{16{a[47]}}, a};
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

  // floor(a*b / 2^16)
  function automatic logic signed [47:0] fmul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t o;
    o.x = sat32(sx32(a.x) - sx32(b.x));
    o.y = sat32(sx32(a.y) - sx32(b.y));
    return o;
  endfunction

  function automatic logic signed [31:0] half_sum(logic signed [31:0] a,
                                                  logic signed [31:0] b);
    logic signed [63:0] s;
    s = sx32(a) + sx32(b);
    return sat32(s >>> 1);
  endfunction

  // one step of the normalizer: a root bit pair, or one quotient bit per axis
  function automatic nrm_t nrm_step(nrm_t s, int idx);
    nrm_t        o;
    logic [35:0] rn;
    logic [35:0] tr;
    logic [48:0] dv;
    int          k;
    o = s;
    k = 0;
    if (idx < SQRT_STEPS) begin
      rn  = {s.rem[33:0], s.v[63:62]};
      o.v = {s.v[61:0], 2'b00};
      tr  = {2'b00, s.root, 2'b01};
      if (rn >= tr) begin
        o.rem  = rn - tr;
        o.root = {s.root[30:0], 1'b1};
      end else begin
        o.rem  = rn;
        o.root = {s.root[30:0], 1'b0};
      end
    end else if (idx < NORM_STEPS) begin
      k  = NORM_STEPS - 1 - idx;
      dv = {17'b0, s.root} << k;
      if (s.rx >= dv) begin
        o.rx    = s.rx - dv;
        o.qx[k] = 1'b1;
      end
      if (s.ry >= dv) begin
        o.ry    = s.ry - dv;
        o.qy[k] = 1'b1;
      end
    end
    return o;
  endfunction

endpackage

FILE: src/wcm_ifs.sv
// ----------------------------------------------------------------------------
// wcm channel interfaces
// Input manifold, result and configuration write channels.
// ----------------------------------------------------------------------------
interface wcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  manifold_type;
  logic [1:0]  point_count;
  logic [63:0] xfa_pos;
  logic [63:0] xfa_rot;
  logic [63:0] xfb_pos;
  logic [63:0] xfb_rot;
  logic [30:0] radius_a;
  logic [30:0] radius_b;
  logic [63:0] local_normal;
  logic [63:0] local_point;
  logic [63:0] clip_point0;
  logic [63:0] clip_point1;
  modport source(output valid, manifold_type, point_count, xfa_pos, xfa_rot, xfb_pos,
                 xfb_rot, radius_a, radius_b, local_normal, local_point, clip_point0,
                 clip_point1, input ready);
  modport sink(input valid, manifold_type, point_count, xfa_pos, xfa_rot, xfb_pos,
               xfb_rot, radius_a, radius_b, local_normal, local_point, clip_point0,
               clip_point1, output ready);
endinterface

interface wcm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_count;
  logic [63:0]        world_normal;
  logic [63:0]        world_point0;
  logic signed [31:0] separation0;
  logic [63:0]        world_point1;
  logic signed [31:0] separation1;
  modport source(output valid, out_count, world_normal, world_point0, separation0,
                 world_point1, separation1, input ready);
  modport sink(input valid, out_count, world_normal, world_point0, separation0,
               world_point1, separation1, output ready);
endinterface

interface wcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: src/world_contact_manifold.sv
// ----------------------------------------------------------------------------
// world_contact_manifold: local contact manifold to world contact points
// Q16.16 transform/normalize/project pipeline, one word per cycle unstalled.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch  carries one manifold word (type, count, both transforms, radii,
//         local normal/point, two clip points). Accepted on valid && ready.
//  out_ch carries one result word per input: count, world normal, two world
//         points and separations. Unused slots and empty manifolds read 0.
//  cfg_ch writes min_dist_sq; always ready, write only while idle.
// Timing:
//  24 register stages. One word per cycle sustained while out_ch is ready;
//  the depth is set by the normalizer, a 32-step root plus 17-bit divide
//  run four steps per stage (13 stages).
// Reset:
//  rst_n low clears every stage valid and sets min_dist_sq to 1.
// Stall:
//  each stage moves when it is empty or the next one moves, so a held
//  out_ch stops only the full stages; empty slots keep taking words.
// ----------------------------------------------------------------------------
module world_contact_manifold #(
  parameter int MAX_POINTS = wcm_pkg::MAX_POINTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wcm_in_if.sink     in_ch,
  wcm_out_if.source  out_ch,
  wcm_cfg_if.sink    cfg_ch
);

  localparam int S_NRM0 = 6;
  localparam int S_NSEL = S_NRM0 + wcm_pkg::NORM_STAGES;
  localparam int S_KMUL = S_NSEL + 1;
  localparam int S_CPT  = S_NSEL + 2;
  localparam int S_MID  = S_NSEL + 3;
  localparam int S_SMUL = S_NSEL + 4;
  localparam int S_LAST = S_NSEL + 5;

  typedef struct packed {
    logic [1:0]         n_out;
    logic               circ;
    logic               face_b;
    logic               big;
    logic signed [31:0] rad_ref;
    logic signed [31:0] rad_inc;
    logic signed [31:0] t0;
    logic signed [31:0] t1;
    logic signed [31:0] sep0;
    logic signed [31:0] sep1;
    wcm_pkg::vec_t      pref;
    wcm_pkg::vec_t      pinc;
    wcm_pkg::vec_t      r1;
    wcm_pkg::vec_t      r2;
    wcm_pkg::vec_t      r3;
    wcm_pkg::vec_t      r4;
    wcm_pkg::vec_t      d0;
    wcm_pkg::vec_t      d1;
    wcm_pkg::vec_t      nrm;
    wcm_pkg::vec_t      ca0;
    wcm_pkg::vec_t      cb0;
    wcm_pkg::vec_t      ca1;
    wcm_pkg::vec_t      cb1;
    wcm_pkg::vec_t      mid0;
    wcm_pkg::vec_t      mid1;
    wcm_pkg::vec_t      dv0;
    wcm_pkg::vec_t      dv1;
  } ctx_t;

  logic [30:0]  min_dist_r;
  logic [S_LAST:1] v_r;
  logic [S_LAST:1] en;
  ctx_t ctx_r   [1:S_LAST];
  ctx_t ctx_nxt [1:S_LAST];

  // stage product registers
  logic signed [47:0] rp_r  [16];
  logic signed [47:0] rp_nxt[16];
  logic signed [63:0] sqx_r, sqy_r;
  logic signed [47:0] dq_r  [4];
  logic [63:0]        sq_r;
  logic signed [47:0] kp_r  [8];
  logic signed [47:0] kp_nxt[8];
  logic signed [47:0] sp_r  [4];

  logic signed [31:0] nx, ny;
  logic               len_zero;

  // input decode
  wcm_pkg::vec_t pa, ra, pb, rb, lnorm, lpt, clip0, clip1;
  wcm_pkg::vec_t rref, rinc;
  wcm_pkg::vec_t rv [4];
  wcm_pkg::vec_t vv [4];
  wcm_pkg::mtype_t mtype;
  logic [1:0]    n_out_in;

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= wcm_pkg::MIN_DIST_RST;
    end else if (cfg_ch.valid) begin
      min_dist_r <= cfg_ch.data;
    end
  end

  // ---------------- flow control ----------------
  // stage k moves when empty or when stage k+1 moves
  always_comb begin
    en[S_LAST] = !v_r[S_LAST] || out_ch.ready;
    for (int k = S_LAST - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_ch.valid;
      end
      for (int k = 2; k <= S_LAST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: decode, rotation products ----------------
  always_comb begin
    pa    = wcm_pkg::vec_t'(in_ch.xfa_pos);
    ra    = wcm_pkg::vec_t'(in_ch.xfa_rot);
    pb    = wcm_pkg::vec_t'(in_ch.xfb_pos);
    rb    = wcm_pkg::vec_t'(in_ch.xfb_rot);
    lnorm = wcm_pkg::vec_t'(in_ch.local_normal);
    lpt   = wcm_pkg::vec_t'(in_ch.local_point);
    clip0 = wcm_pkg::vec_t'(in_ch.clip_point0);
    clip1 = wcm_pkg::vec_t'(in_ch.clip_point1);
    mtype = wcm_pkg::mtype_t'(in_ch.manifold_type);

    unique case (mtype)
      wcm_pkg::MT_CIRCLES: n_out_in = (in_ch.point_count != 2'd0) ? 2'd1 : 2'd0;
      wcm_pkg::MT_FACE_A, wcm_pkg::MT_FACE_B: begin
        n_out_in = (in_ch.point_count > 2'(MAX_POINTS)) ? 2'(MAX_POINTS)
                                                       : in_ch.point_count;
      end
      default: n_out_in = 2'd0;
    endcase

    // circles uses A as reference, B as incident
    rref = (mtype == wcm_pkg::MT_FACE_B) ? rb : ra;
    rinc = (mtype == wcm_pkg::MT_FACE_B) ? ra : rb;
    // rotations: plane/centre A, clip0/centre B, normal, clip1
    rv[0] = rref;  vv[0] = lpt;
    rv[1] = rinc;  vv[1] = clip0;
    rv[2] = rref;  vv[2] = lnorm;
    rv[3] = rinc;  vv[3] = clip1;
    for (int j = 0; j < 4; j++) begin
      rp_nxt[4*j+0] = wcm_pkg::fmul(rv[j].x, vv[j].x);
      rp_nxt[4*j+1] = wcm_pkg::fmul(rv[j].y, vv[j].y);
      rp_nxt[4*j+2] = wcm_pkg::fmul(rv[j].y, vv[j].x);
      rp_nxt[4*j+3] = wcm_pkg::fmul(rv[j].x, vv[j].y);
    end
  end

  // ---------------- per-stage context ----------------
  always_comb begin
    logic signed [63:0] acc;
    wcm_pkg::vec_t p1;
    wcm_pkg::vec_t nn;

    for (int k = 2; k <= S_LAST; k++) begin
      ctx_nxt[k] = ctx_r[k-1];
    end

    // stage 1
    ctx_nxt[1]         = '0;
    ctx_nxt[1].n_out   = n_out_in;
    ctx_nxt[1].circ    = (mtype == wcm_pkg::MT_CIRCLES);
    ctx_nxt[1].face_b  = (mtype == wcm_pkg::MT_FACE_B);
    ctx_nxt[1].rad_ref = (mtype == wcm_pkg::MT_FACE_B) ? $signed({1'b0, in_ch.radius_b})
                                                       : $signed({1'b0, in_ch.radius_a});
    ctx_nxt[1].rad_inc = (mtype == wcm_pkg::MT_FACE_B) ? $signed({1'b0, in_ch.radius_a})
                                                       : $signed({1'b0, in_ch.radius_b});
    ctx_nxt[1].pref    = (mtype == wcm_pkg::MT_FACE_B) ? pb : pa;
    ctx_nxt[1].pinc    = (mtype == wcm_pkg::MT_FACE_B) ? pa : pb;

    // stage 2: finish rotations, add positions
    ctx_nxt[2].r1.x = wcm_pkg::sat32(wcm_pkg::sx48(rp_r[0]) - wcm_pkg::sx48(rp_r[1])
                                     + wcm_pkg::sx32(ctx_r[1].pref.x));
    ctx_nxt[2].r1.y = wcm_pkg::sat32(wcm_pkg::sx48(rp_r[2]) + wcm_pkg::sx48(rp_r[3])
                                     + wcm_pkg::sx32(ctx_r[1].pref.y));
    ctx_nxt[2].r2.x = wcm_pkg::sat32(wcm_pkg::sx48(rp_r[4]) - wcm_pkg::sx48(rp_r[5])
                                     + wcm_pkg::sx32(ctx_r[1].pinc.x));
    ctx_nxt[2].r2.y = wcm_pkg::sat32(wcm_pkg::sx48(rp_r[6]) + wcm_pkg::sx48(rp_r[7])
                                     + wcm_pkg::sx32(ctx_r[1].pinc.y));
    ctx_nxt[2].r3.x = wcm_pkg::sat32(wcm_pkg::sx48(rp_r[8]) - wcm_pkg::sx48(rp_r[9]));
    ctx_nxt[2].r3.y = wcm_pkg::sat32(wcm_pkg::sx48(rp_r[10]) + wcm_pkg::sx48(rp_r[11]));
    ctx_nxt[2].r4.x = wcm_pkg::sat32(wcm_pkg::sx48(rp_r[12]) - wcm_pkg::sx48(rp_r[13])
                                     + wcm_pkg::sx32(ctx_r[1].pinc.x));
    ctx_nxt[2].r4.y = wcm_pkg::sat32(wcm_pkg::sx48(rp_r[14]) + wcm_pkg::sx48(rp_r[15])
                                     + wcm_pkg::sx32(ctx_r[1].pinc.y));

    // stage 3: offsets from reference (circles: centre delta)
    ctx_nxt[3].d0 = wcm_pkg::vsub(ctx_r[2].r2, ctx_r[2].r1);
    ctx_nxt[3].d1 = wcm_pkg::vsub(ctx_r[2].r4, ctx_r[2].r1);

    // stage 5: threshold test, face offsets t = rad_ref - dot
    ctx_nxt[5].big = ((sqx_r + sqy_r) >> 16) > 64'(min_dist_r);
    acc = wcm_pkg::sx32(wcm_pkg::sat32(wcm_pkg::sx48(dq_r[0]) + wcm_pkg::sx48(dq_r[1])));
    ctx_nxt[5].t0 = wcm_pkg::sat32(wcm_pkg::sx32(ctx_r[4].rad_ref) - acc);
    acc = wcm_pkg::sx32(wcm_pkg::sat32(wcm_pkg::sx48(dq_r[2]) + wcm_pkg::sx48(dq_r[3])));
    ctx_nxt[5].t1 = wcm_pkg::sat32(wcm_pkg::sx32(ctx_r[4].rad_ref) - acc);

    // normal select: circles keeps (1,0) when close or zero root
    if (!ctx_r[S_NSEL-1].circ) begin
      ctx_nxt[S_NSEL].nrm = ctx_r[S_NSEL-1].r3;
    end else if (ctx_r[S_NSEL-1].big && !len_zero) begin
      ctx_nxt[S_NSEL].nrm.x = nx;
      ctx_nxt[S_NSEL].nrm.y = ny;
    end else begin
      ctx_nxt[S_NSEL].nrm.x = wcm_pkg::ONE_Q16;
      ctx_nxt[S_NSEL].nrm.y = '0;
    end

    // skin points: P1 + k1*n and P2 - k2*n
    p1 = ctx_r[S_KMUL].circ ? ctx_r[S_KMUL].r1 : ctx_r[S_KMUL].r2;
    ctx_nxt[S_CPT].ca0.x = wcm_pkg::sat32(wcm_pkg::sx32(p1.x) + wcm_pkg::sx48(kp_r[0]));
    ctx_nxt[S_CPT].ca0.y = wcm_pkg::sat32(wcm_pkg::sx32(p1.y) + wcm_pkg::sx48(kp_r[1]));
    ctx_nxt[S_CPT].cb0.x = wcm_pkg::sat32(wcm_pkg::sx32(ctx_r[S_KMUL].r2.x)
                                          - wcm_pkg::sx48(kp_r[2]));
    ctx_nxt[S_CPT].cb0.y = wcm_pkg::sat32(wcm_pkg::sx32(ctx_r[S_KMUL].r2.y)
                                          - wcm_pkg::sx48(kp_r[3]));
    ctx_nxt[S_CPT].ca1.x = wcm_pkg::sat32(wcm_pkg::sx32(ctx_r[S_KMUL].r4.x)
                                          + wcm_pkg::sx48(kp_r[4]));
    ctx_nxt[S_CPT].ca1.y = wcm_pkg::sat32(wcm_pkg::sx32(ctx_r[S_KMUL].r4.y)
                                          + wcm_pkg::sx48(kp_r[5]));
    ctx_nxt[S_CPT].cb1.x = wcm_pkg::sat32(wcm_pkg::sx32(ctx_r[S_KMUL].r4.x)
                                          - wcm_pkg::sx48(kp_r[6]));
    ctx_nxt[S_CPT].cb1.y = wcm_pkg::sat32(wcm_pkg::sx32(ctx_r[S_KMUL].r4.y)
                                          - wcm_pkg::sx48(kp_r[7]));

    // midpoints and separation vectors
    ctx_nxt[S_MID].mid0.x = wcm_pkg::half_sum(ctx_r[S_CPT].ca0.x, ctx_r[S_CPT].cb0.x);
    ctx_nxt[S_MID].mid0.y = wcm_pkg::half_sum(ctx_r[S_CPT].ca0.y, ctx_r[S_CPT].cb0.y);
    ctx_nxt[S_MID].mid1.x = wcm_pkg::half_sum(ctx_r[S_CPT].ca1.x, ctx_r[S_CPT].cb1.x);
    ctx_nxt[S_MID].mid1.y = wcm_pkg::half_sum(ctx_r[S_CPT].ca1.y, ctx_r[S_CPT].cb1.y);
    ctx_nxt[S_MID].dv0    = wcm_pkg::vsub(ctx_r[S_CPT].cb0, ctx_r[S_CPT].ca0);
    ctx_nxt[S_MID].dv1    = wcm_pkg::vsub(ctx_r[S_CPT].cb1, ctx_r[S_CPT].ca1);

    // output stage: separations, blanking, face B normal flip
    ctx_nxt[S_LAST].sep0 = wcm_pkg::sat32(wcm_pkg::sx48(sp_r[0]) + wcm_pkg::sx48(sp_r[1]));
    ctx_nxt[S_LAST].sep1 = wcm_pkg::sat32(wcm_pkg::sx48(sp_r[2]) + wcm_pkg::sx48(sp_r[3]));
    if (ctx_r[S_SMUL].n_out < 2'd1) begin
      ctx_nxt[S_LAST].mid0 = '0;
      ctx_nxt[S_LAST].sep0 = '0;
    end
    if (ctx_r[S_SMUL].n_out < 2'd2) begin
      ctx_nxt[S_LAST].mid1 = '0;
      ctx_nxt[S_LAST].sep1 = '0;
    end
    nn = ctx_r[S_SMUL].nrm;
    if (ctx_r[S_SMUL].n_out == 2'd0) begin
      ctx_nxt[S_LAST].nrm = '0;
    end else if (ctx_r[S_SMUL].face_b) begin
      ctx_nxt[S_LAST].nrm.x = wcm_pkg::sat32(-wcm_pkg::sx32(nn.x));
      ctx_nxt[S_LAST].nrm.y = wcm_pkg::sat32(-wcm_pkg::sx32(nn.y));
    end
  end

  // scale factors for the skin points
  always_comb begin
    logic signed [31:0] k1a;
    wcm_pkg::vec_t      n;
    n   = ctx_r[S_NSEL].nrm;
    k1a = ctx_r[S_NSEL].circ ? ctx_r[S_NSEL].rad_ref : ctx_r[S_NSEL].t0;
    kp_nxt[0] = wcm_pkg::fmul(k1a, n.x);
    kp_nxt[1] = wcm_pkg::fmul(k1a, n.y);
    kp_nxt[2] = wcm_pkg::fmul(ctx_r[S_NSEL].rad_inc, n.x);
    kp_nxt[3] = wcm_pkg::fmul(ctx_r[S_NSEL].rad_inc, n.y);
    kp_nxt[4] = wcm_pkg::fmul(ctx_r[S_NSEL].t1, n.x);
    kp_nxt[5] = wcm_pkg::fmul(ctx_r[S_NSEL].t1, n.y);
    kp_nxt[6] = kp_nxt[2];
    kp_nxt[7] = kp_nxt[3];
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    for (int k = 1; k <= S_LAST; k++) begin
      if (en[k]) begin
        ctx_r[k] <= ctx_nxt[k];
      end
    end
    if (en[1]) begin
      rp_r <= rp_nxt;
    end
    if (en[4]) begin
      sqx_r   <= ctx_r[3].d0.x * ctx_r[3].d0.x;
      sqy_r   <= ctx_r[3].d0.y * ctx_r[3].d0.y;
      dq_r[0] <= wcm_pkg::fmul(ctx_r[3].d0.x, ctx_r[3].r3.x);
      dq_r[1] <= wcm_pkg::fmul(ctx_r[3].d0.y, ctx_r[3].r3.y);
      dq_r[2] <= wcm_pkg::fmul(ctx_r[3].d1.x, ctx_r[3].r3.x);
      dq_r[3] <= wcm_pkg::fmul(ctx_r[3].d1.y, ctx_r[3].r3.y);
    end
    if (en[5]) begin
      sq_r <= 64'(sqx_r + sqy_r);
    end
    if (en[S_KMUL]) begin
      kp_r <= kp_nxt;
    end
    if (en[S_SMUL]) begin
      sp_r[0] <= wcm_pkg::fmul(ctx_r[S_MID].dv0.x, ctx_r[S_MID].nrm.x);
      sp_r[1] <= wcm_pkg::fmul(ctx_r[S_MID].dv0.y, ctx_r[S_MID].nrm.y);
      sp_r[2] <= wcm_pkg::fmul(ctx_r[S_MID].dv1.x, ctx_r[S_MID].nrm.x);
      sp_r[3] <= wcm_pkg::fmul(ctx_r[S_MID].dv1.y, ctx_r[S_MID].nrm.y);
    end
  end

  // circles normal: d / isqrt(|d|^2), stages S_NRM0 .. S_NSEL-1
  wcm_norm u_norm (
    .clk      (clk),
    .en       (en[S_NRM0 +: wcm_pkg::NORM_STAGES]),
    .sq       (sq_r),
    .dx       (ctx_r[5].d0.x),
    .dy       (ctx_r[5].d0.y),
    .nx       (nx),
    .ny       (ny),
    .len_zero (len_zero)
  );

  // ---------------- result word ----------------
  assign out_ch.valid        = v_r[S_LAST];
  assign out_ch.out_count    = ctx_r[S_LAST].n_out;
  assign out_ch.world_normal = 64'(ctx_r[S_LAST].nrm);
  assign out_ch.world_point0 = 64'(ctx_r[S_LAST].mid0);
  assign out_ch.separation0  = ctx_r[S_LAST].sep0;
  assign out_ch.world_point1 = 64'(ctx_r[S_LAST].mid1);
  assign out_ch.separation1  = ctx_r[S_LAST].sep1;

  // ---------------- assertions ----------------
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_count == 2'd0 |->
      out_ch.world_normal == '0 && out_ch.world_point0 == '0 && out_ch.separation0 == '0)
    else $error("empty manifold word carries nonzero fields");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.out_count <= 2'(MAX_POINTS))
    else $error("result count above point limit");

  a_slot1_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_count < 2'd2 |->
      out_ch.world_point1 == '0 && out_ch.separation1 == '0)
    else $error("unused second slot not blanked");

endmodule

FILE: src/wcm_norm.sv
// ----------------------------------------------------------------------------
// wcm_norm: pipelined vector normalizer
// Bit-pair square root then restoring divide, four steps per stage.
// ----------------------------------------------------------------------------
module wcm_norm (
  input  logic                                clk,
  input  logic [wcm_pkg::NORM_STAGES-1:0]     en,
  input  logic [63:0]                         sq,
  input  logic signed [31:0]                  dx,
  input  logic signed [31:0]                  dy,
  output logic signed [31:0]                  nx,
  output logic signed [31:0]                  ny,
  output logic                                len_zero
);

  localparam int NS = wcm_pkg::NORM_STAGES;
  localparam int PS = wcm_pkg::NORM_PER_STAGE;

  wcm_pkg::nrm_t st_r [NS];
  wcm_pkg::nrm_t init;
  logic [31:0]   absx;
  logic [31:0]   absy;
  logic signed [31:0] qxs;
  logic signed [31:0] qys;

  always_comb begin
    absx = dx[31] ? 32'(-dx) : 32'(dx);
    absy = dy[31] ? 32'(-dy) : 32'(dy);
    init      = '0;
    init.v    = sq;
    init.rx   = {1'b0, absx, 16'b0};
    init.ry   = {1'b0, absy, 16'b0};
    init.negx = dx[31];
    init.negy = dy[31];
  end

  for (genvar j = 0; j < NS; j++) begin : g_st
    wcm_pkg::nrm_t src;
    wcm_pkg::nrm_t res;
    if (j == 0) begin : g_first
      assign src = init;
    end else begin : g_next
      assign src = st_r[j-1];
    end
    always_comb begin
      res = src;
      for (int i = 0; i < PS; i++) begin
        res = wcm_pkg::nrm_step(res, j * PS + i);
      end
    end
    always_ff @(posedge clk) begin
      if (en[j]) begin
        st_r[j] <= res;
      end
    end
  end

  always_comb begin
    qxs = $signed({15'b0, st_r[NS-1].qx});
    qys = $signed({15'b0, st_r[NS-1].qy});
    nx  = st_r[NS-1].negx ? -qxs : qxs;
    ny  = st_r[NS-1].negy ? -qys : qys;
    len_zero = (st_r[NS-1].root == '0);
  end

endmodule
